// ===== design/i2crb_pkg.sv =====
// Package for the register bank with coarse/fine period timer.
// Holds operation codes, register indexes, reset values and the entry modulo helper.
// Used by i2c_register_bank_coarse_fine_timer_top and i2crb_pair_mem.
`default_nettype none

package i2crb_pkg;

   // Sizes
   localparam int unsigned TABLE_ENTRIES = 128;
   localparam int unsigned REG_COUNT     = 8;
   localparam int unsigned PTR_W         = 3;
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned PAIR_W        = 2 * BYTE_W;

   // Operation codes carried in tuser
   localparam logic [1:0] OP_SET_PTR = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   // Timer phase codes
   localparam logic [1:0] PH_STOP   = 2'd0;
   localparam logic [1:0] PH_COARSE = 2'd1;
   localparam logic [1:0] PH_FINE   = 2'd2;

   // Register indexes
   localparam logic [PTR_W-1:0] REG_PRESCALE = 3'd0;
   localparam logic [PTR_W-1:0] REG_COARSE_N = 3'd1;
   localparam logic [PTR_W-1:0] REG_FINE_LIM = 3'd2;
   localparam logic [PTR_W-1:0] REG_ENTRY    = 3'd5;
   localparam logic [PTR_W-1:0] REG_COARSE_B = 3'd6;
   localparam logic [PTR_W-1:0] REG_FINE_B   = 3'd7;

   // Timer constants
   localparam logic [BYTE_W-1:0] COARSE_LIMIT = 8'd254;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef byte_type bank_type [REG_COUNT];

   // Register bank contents after reset
   localparam bank_type BANK_RESET = '{8'd9, 8'd123, 8'd8, 8'd127, 8'd4, 8'd0, 8'd0, 8'd0};

   // Remainder of a byte by a constant entry count through a reciprocal multiply.
   // recip is 2**16 / entries + 1, which gives the exact quotient for every byte.
   function automatic logic [BYTE_W-1:0] entry_mod(input logic [BYTE_W-1:0] value,
                                                   input int unsigned      recip,
                                                   input int unsigned      entries);
      logic [23:0]       prod;
      logic [BYTE_W-1:0] quot;
      logic [BYTE_W-1:0] back;
      prod = 24'(value) * 24'(recip);
      quot = prod[23:16];
      back = 8'(16'(quot) * 16'(entries));
      return value - back;
   endfunction

endpackage

`default_nettype wire

// ===== design/i2crb_pair_mem.sv =====
// Coarse/fine pair table: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on i2crb_pkg for widths.
`default_nettype none

module i2crb_pair_mem #(
   parameter int unsigned ENTRIES = i2crb_pkg::TABLE_ENTRIES,
   localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [IDX_W-1:0]               wr_idx,
   input  wire logic [i2crb_pkg::PAIR_W-1:0]   wr_data,
   input  wire logic                           rd_en,
   input  wire logic [IDX_W-1:0]               rd_idx,
   output logic      [i2crb_pkg::PAIR_W-1:0]   rd_data
);

   logic [i2crb_pkg::PAIR_W-1:0] mem_ff [ENTRIES];
   logic [ENTRIES-1:0]           valid_ff;
   logic [i2crb_pkg::PAIR_W-1:0] rdata_ff;
   logic                         hit_ff;

   // Write storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
   end

   // Mark written entries, drop all marks on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_idx];
         hit_ff   <= valid_ff[rd_idx];
      end
   end

   assign rd_data = hit_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

// ===== design/i2c_register_bank_coarse_fine_timer_top.sv =====
// Top level: register bank with pointer, pair table and coarse/fine period timer.
// Depends on i2crb_pkg and i2crb_pair_mem.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser = op[1:0], tdata = data[7:0]
//   rsp      out  rsp_tvalid/rsp_tready  tdata = read_data[7:0], onset[8], phase[10:9]
//
// Bank, pointer and timer update at the accepting edge, and each result leaves through
// the input stage and then the output register. A new item is accepted every cycle
// while the output is not stalled; the table read port is used once per read of a pair register.
// Reset (synchronous, high) restores the bank, timer and pointer and clears the table
// valid bits at once. A stalled output holds the input stage, which holds the input.
`default_nettype none

module i2c_register_bank_coarse_fine_timer_top #(
   parameter int unsigned TABLE_ENTRIES = i2crb_pkg::TABLE_ENTRIES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data[7:0]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // read_data[7:0], onset_level[8], timer_phase[10:9]
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned BW    = i2crb_pkg::BYTE_W;
   localparam int unsigned PW    = i2crb_pkg::PTR_W;
   localparam int unsigned ENTRY_RECIP = 65536 / TABLE_ENTRIES + 1;

   // Source of read_data in the input stage
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_BANK   = 2'd1;
   localparam logic [1:0] KIND_COARSE = 2'd2;
   localparam logic [1:0] KIND_FINE   = 2'd3;

   logic                accept;
   logic [1:0]          op;
   logic [BW-1:0]       data;

   i2crb_pkg::bank_type bank_ff;
   i2crb_pkg::bank_type bank_in;
   logic [PW-1:0]       pointer_ff, pointer_in;
   logic [IDX_W-1:0]    entry_ff, entry_in;
   logic [1:0]          phase_ff, phase_in;
   logic [BW-1:0]       lap_count_ff, lap_count_in;
   logic [BW-1:0]       tick_count_ff, tick_count_in;
   logic [BW-1:0]       lap_limit_ff, lap_limit_in;
   logic                onset_ff, onset_in;
   logic [BW-1:0]       lap_next;

   logic                mem_wr, mem_rd;
   logic [i2crb_pkg::PAIR_W-1:0] mem_wdata, mem_rdata;

   logic                a_valid_ff;
   logic [1:0]          a_kind_ff, kind_in;
   logic [BW-1:0]       a_byte_ff, byte_in;
   logic                a_onset_ff;
   logic [1:0]          a_phase_ff;
   logic                a_move;
   logic [BW-1:0]       rd_byte;

   logic                b_valid_ff;
   logic [15:0]         b_data_ff;

   assign op     = req_tuser;
   assign data   = req_tdata;
   assign a_move = a_valid_ff && (!b_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || a_move;
   assign accept = req_tvalid && req_tready;
   assign lap_next = lap_count_ff + 8'd1;

   // Next state of bank, pointer and timer for the offered item
   always_comb begin
      bank_in       = bank_ff;
      pointer_in    = pointer_ff;
      entry_in      = entry_ff;
      phase_in      = phase_ff;
      lap_count_in  = lap_count_ff;
      tick_count_in = tick_count_ff;
      lap_limit_in  = lap_limit_ff;
      onset_in      = onset_ff;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      mem_wdata     = {data, bank_ff[i2crb_pkg::REG_COARSE_B]};
      kind_in       = KIND_NONE;
      byte_in       = bank_ff[pointer_ff];
      unique case (op)
         i2crb_pkg::OP_SET_PTR: begin
            pointer_in = data[PW-1:0];
         end
         i2crb_pkg::OP_WRITE: begin
            bank_in[pointer_ff] = data;
            pointer_in = pointer_ff + 3'd1;
            if (pointer_ff <= i2crb_pkg::REG_FINE_LIM) begin
               // Restart the timer from the updated registers
               if (bank_in[i2crb_pkg::REG_COARSE_N] != 8'd0) begin
                  phase_in     = i2crb_pkg::PH_COARSE;
                  lap_limit_in = i2crb_pkg::COARSE_LIMIT;
               end else begin
                  phase_in     = i2crb_pkg::PH_FINE;
                  lap_limit_in = bank_in[i2crb_pkg::REG_FINE_LIM];
               end
               lap_count_in  = 8'd0;
               tick_count_in = 8'd0;
            end
            if (pointer_ff == i2crb_pkg::REG_ENTRY) begin
               entry_in = IDX_W'(i2crb_pkg::entry_mod(data, ENTRY_RECIP, TABLE_ENTRIES));
            end
            if (pointer_ff == i2crb_pkg::REG_FINE_B) begin
               mem_wr = 1'b1;
            end
         end
         i2crb_pkg::OP_READ: begin
            pointer_in = pointer_ff + 3'd1;
            if (pointer_ff == i2crb_pkg::REG_COARSE_B) begin
               kind_in = KIND_COARSE;
               mem_rd  = 1'b1;
            end else if (pointer_ff == i2crb_pkg::REG_FINE_B) begin
               kind_in = KIND_FINE;
               mem_rd  = 1'b1;
            end else begin
               kind_in = KIND_BANK;
            end
         end
         i2crb_pkg::OP_TICK: begin
            if (tick_count_ff >= lap_limit_ff) begin
               tick_count_in = 8'd0;
               if (phase_ff == i2crb_pkg::PH_COARSE) begin
                  lap_count_in = lap_next;
                  if (lap_next >= bank_ff[i2crb_pkg::REG_COARSE_N]) begin
                     phase_in     = i2crb_pkg::PH_FINE;
                     lap_limit_in = bank_ff[i2crb_pkg::REG_FINE_LIM];
                  end
               end else if (phase_ff == i2crb_pkg::PH_FINE) begin
                  // Toggle onset and restart
                  onset_in      = !onset_ff;
                  lap_count_in  = 8'd0;
                  if (bank_ff[i2crb_pkg::REG_COARSE_N] != 8'd0) begin
                     phase_in     = i2crb_pkg::PH_COARSE;
                     lap_limit_in = i2crb_pkg::COARSE_LIMIT;
                  end else begin
                     phase_in     = i2crb_pkg::PH_FINE;
                     lap_limit_in = bank_ff[i2crb_pkg::REG_FINE_LIM];
                  end
               end
            end else begin
               tick_count_in = tick_count_ff + 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Commit state at the accepting edge
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff       <= i2crb_pkg::BANK_RESET;
         pointer_ff    <= '0;
         entry_ff      <= '0;
         phase_ff      <= i2crb_pkg::PH_COARSE;
         lap_count_ff  <= '0;
         tick_count_ff <= '0;
         lap_limit_ff  <= i2crb_pkg::COARSE_LIMIT;
         onset_ff      <= 1'b0;
      end else if (accept) begin
         bank_ff       <= bank_in;
         pointer_ff    <= pointer_in;
         entry_ff      <= entry_in;
         phase_ff      <= phase_in;
         lap_count_ff  <= lap_count_in;
         tick_count_ff <= tick_count_in;
         lap_limit_ff  <= lap_limit_in;
         onset_ff      <= onset_in;
      end
   end

   // Pair table, addressed by the selected entry
   i2crb_pair_mem #(
      .ENTRIES (TABLE_ENTRIES)
   ) u_pair_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && mem_wr),
      .wr_idx  (entry_ff),
      .wr_data (mem_wdata),
      .rd_en   (accept && mem_rd),
      .rd_idx  (entry_ff),
      .rd_data (mem_rdata)
   );

   // Input stage: hold the item's result fields while the table read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_kind_ff  <= kind_in;
         a_byte_ff  <= byte_in;
         a_onset_ff <= onset_in;
         a_phase_ff <= phase_in;
      end
   end

   // Select the read byte
   always_comb begin
      unique case (a_kind_ff)
         KIND_BANK:   rd_byte = a_byte_ff;
         KIND_COARSE: rd_byte = mem_rdata[BW-1:0];
         KIND_FINE:   rd_byte = mem_rdata[2*BW-1:BW];
         default:     rd_byte = '0;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_move) begin
         b_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_data_ff <= {5'd0, a_phase_ff, a_onset_ff, rd_byte};
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_data_ff;

   // Checks
   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      tick_count_ff <= lap_limit_ff)
      else $error("tick count passed the lap limit");

   a_phase_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == i2crb_pkg::PH_COARSE || phase_ff == i2crb_pkg::PH_FINE)
      else $error("timer left the counting phases");

   a_move_lands: assert property (@(posedge clock) disable iff (reset)
      a_move |=> rsp_tvalid)
      else $error("input stage moved but no result is shown");

   a_zero_rd: assert property (@(posedge clock) disable iff (reset)
      (a_move && a_kind_ff == KIND_NONE) |=> rsp_tdata[7:0] == 8'd0)
      else $error("non-read item returned read data");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the register bank with coarse/fine period timer.
// Drives item streams into i2c_register_bank_coarse_fine_timer_top and checks every result
// against directed expectations or an in-bench shadow of the bank, pair table and timer; depends on i2crb_pkg.
`default_nettype none

module tb;

   localparam int ENTRY_COUNT  = int'(i2crb_pkg::TABLE_ENTRIES);
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 10;

   typedef struct packed {
      logic [7:0] rd;
      logic       onset;
      logic [1:0] phase;
   } timer_result_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       data;
      logic             typed;
      timer_result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic [1:0]  req_tuser = i2crb_pkg::OP_SET_PTR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   i2c_register_bank_coarse_fine_timer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the block state
   logic [7:0] shadow_bank [i2crb_pkg::REG_COUNT];
   logic [7:0] shadow_pairs [256];
   logic [2:0] shadow_ptr;
   logic [1:0] shadow_phase;
   logic [7:0] shadow_laps;
   logic [7:0] shadow_ticks;
   logic [7:0] shadow_limit;
   logic       shadow_onset;

   timer_result_type pending_results [$];
   stim_row_type     offered_rows [$];
   stim_row_type     directed_rows [$];

   int errors = 0;
   int cycles = 0;
   int items_sent = 0;
   int op_seen [4] = '{0, 0, 0, 0};
   int onset_toggles = 0;
   int fine_entries = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_request = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow reset
   initial begin
      for (int i = 0; i < i2crb_pkg::REG_COUNT; i++) shadow_bank[i] = i2crb_pkg::BANK_RESET[i];
      for (int i = 0; i < 256; i++) shadow_pairs[i] = 8'd0;
      shadow_ptr   = 3'd0;
      shadow_phase = i2crb_pkg::PH_COARSE;
      shadow_laps  = 8'd0;
      shadow_ticks = 8'd0;
      shadow_limit = i2crb_pkg::COARSE_LIMIT;
      shadow_onset = 1'b0;
   end

   function automatic logic [7:0] pair_base();
      return 8'((int'(shadow_bank[i2crb_pkg::REG_ENTRY]) % ENTRY_COUNT) * 2);
   endfunction

   task automatic restart_timer_shadow();
      if (shadow_bank[i2crb_pkg::REG_COARSE_N] != 8'd0) begin
         shadow_phase = i2crb_pkg::PH_COARSE;
         shadow_limit = i2crb_pkg::COARSE_LIMIT;
      end else begin
         shadow_phase = i2crb_pkg::PH_FINE;
         shadow_limit = shadow_bank[i2crb_pkg::REG_FINE_LIM];
      end
      shadow_laps  = 8'd0;
      shadow_ticks = 8'd0;
   endtask

   // Apply one item to the shadow state and return the result it causes
   task automatic apply_bank_item(input logic [1:0] op, input logic [7:0] data,
                                  output timer_result_type res);
      logic [7:0] base;
      logic [7:0] rd;
      rd = 8'd0;
      base = pair_base();
      unique case (op)
         i2crb_pkg::OP_SET_PTR: begin
            shadow_ptr = data[2:0];
         end
         i2crb_pkg::OP_WRITE: begin
            shadow_bank[shadow_ptr] = data;
            if (shadow_ptr <= i2crb_pkg::REG_FINE_LIM) begin
               restart_timer_shadow();
            end else if (shadow_ptr == i2crb_pkg::REG_FINE_B) begin
               base = pair_base();
               shadow_pairs[base]         = shadow_bank[i2crb_pkg::REG_COARSE_B];
               shadow_pairs[8'(base + 1)] = shadow_bank[i2crb_pkg::REG_FINE_B];
            end
            shadow_ptr = shadow_ptr + 3'd1;
         end
         i2crb_pkg::OP_READ: begin
            if (shadow_ptr == i2crb_pkg::REG_COARSE_B) rd = shadow_pairs[base];
            else if (shadow_ptr == i2crb_pkg::REG_FINE_B) rd = shadow_pairs[8'(base + 1)];
            else rd = shadow_bank[shadow_ptr];
            shadow_ptr = shadow_ptr + 3'd1;
         end
         default: begin
            // End the lap once the count has reached its limit
            if (shadow_ticks >= shadow_limit) begin
               shadow_ticks = 8'd0;
               if (shadow_phase == i2crb_pkg::PH_COARSE) begin
                  shadow_laps = shadow_laps + 8'd1;
                  if (shadow_laps >= shadow_bank[i2crb_pkg::REG_COARSE_N]) begin
                     shadow_phase = i2crb_pkg::PH_FINE;
                     shadow_limit = shadow_bank[i2crb_pkg::REG_FINE_LIM];
                     fine_entries++;
                  end
               end else if (shadow_phase == i2crb_pkg::PH_FINE) begin
                  shadow_onset = ~shadow_onset;
                  onset_toggles++;
                  restart_timer_shadow();
               end
            end else begin
               shadow_ticks = shadow_ticks + 8'd1;
            end
         end
      endcase
      res.rd    = rd;
      res.onset = shadow_onset;
      res.phase = shadow_phase;
   endtask

   // Predict on each accepted item, check each accepted result, and watch the time budget
   timer_result_type mon_pred;
   timer_result_type mon_got;
   timer_result_type mon_want;
   stim_row_type     mon_row;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            mon_row = offered_rows.pop_front();
            apply_bank_item(req_tuser, req_tdata, mon_pred);
            op_seen[req_tuser]++;
            pending_results.push_back(mon_row.typed ? mon_row.want : mon_pred);
         end
         if (rsp_tvalid && rsp_tready) begin
            mon_got.rd    = rsp_tdata[7:0];
            mon_got.onset = rsp_tdata[8];
            mon_got.phase = rsp_tdata[10:9];
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("Result with nothing expected: tdata=%h", rsp_tdata);
            end else begin
               mon_want = pending_results.pop_front();
               if (mon_got !== mon_want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("Mismatch at cycle %0d: read_data exp %h got %h",
                              cycles, mon_want.rd, mon_got.rd);
                     $display("   onset exp %b got %b, phase exp %0d got %0d",
                              mon_want.onset, mon_got.onset, mon_want.phase, mon_got.phase);
                  end
               end
            end
         end
      end
   end

   // Drive ready: random stalls, plus one long hold-off counted here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_request && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left = HOLD_CYCLES;
         hold_taken = 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one item and hold it until accepted
   task automatic offer_item(input stim_row_type row);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      offered_rows.push_back(row);
      req_tvalid <= 1'b1;
      req_tuser  <= row.op;
      req_tdata  <= row.data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic put(input int op, input int data);
      stim_row_type row;
      row = '0;
      row.op = 2'(op);
      row.data = 8'(data);
      offer_item(row);
   endtask

   task automatic add_row(input logic [1:0] op, input logic [7:0] data,
                          input logic typed, input logic [7:0] rd,
                          input logic onset, input logic [1:0] phase);
      stim_row_type row;
      row.op = op;
      row.data = data;
      row.typed = typed;
      row.want.rd = rd;
      row.want.onset = onset;
      row.want.phase = phase;
      directed_rows.push_back(row);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 || offered_rows.size() != 0) @(negedge clock);
   endtask

   // Random part: mostly timer programs with tick runs and table traffic, some noise
   task automatic run_random(input int stop_at);
      int kind;
      int coarse;
      int fine;
      int burst;
      int laps_needed;
      while (items_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            put(i2crb_pkg::OP_SET_PTR, $urandom_range(31) * 8 + i2crb_pkg::REG_PRESCALE);
            put(i2crb_pkg::OP_WRITE, $urandom_range(255));
            kind = $urandom_range(99);
            coarse = (kind < 60) ? 0 : (kind < 90) ? 1 : $urandom_range(2, 255);
            fine = ($urandom_range(99) < 70) ? $urandom_range(15) : $urandom_range(255);
            put(i2crb_pkg::OP_WRITE, coarse);
            put(i2crb_pkg::OP_WRITE, fine);
            // Each coarse lap takes 255 ticks, the fine lap its limit plus one
            laps_needed = coarse * 255 + fine + 1;
            if (laps_needed <= 600 && $urandom_range(99) < 60)
               burst = laps_needed + $urandom_range(fine + 1);
            else
               burst = $urandom_range(1, 40);
            // Keep the run close to its item budget
            if (burst > stop_at - items_sent)
               burst = (stop_at > items_sent) ? stop_at - items_sent : 0;
            repeat (burst) put(i2crb_pkg::OP_TICK, $urandom_range(255));
         end else if (kind < 70) begin
            put(i2crb_pkg::OP_SET_PTR, $urandom_range(31) * 8 + i2crb_pkg::REG_ENTRY);
            put(i2crb_pkg::OP_WRITE, $urandom_range(1) ? $urandom_range(3) : $urandom_range(255));
            put(i2crb_pkg::OP_WRITE, $urandom_range(255));
            put(i2crb_pkg::OP_WRITE, $urandom_range(255));
            if ($urandom_range(1)) begin
               put(i2crb_pkg::OP_SET_PTR, $urandom_range(31) * 8 + i2crb_pkg::REG_ENTRY);
               put(i2crb_pkg::OP_WRITE,
                   $urandom_range(1) ? $urandom_range(3) : $urandom_range(255));
               put(i2crb_pkg::OP_READ, $urandom_range(255));
               put(i2crb_pkg::OP_READ, $urandom_range(255));
            end
         end else if (kind < 85) begin
            put(i2crb_pkg::OP_SET_PTR, $urandom_range(255));
            repeat ($urandom_range(1, 9)) put(i2crb_pkg::OP_READ, $urandom_range(255));
         end else begin
            repeat ($urandom_range(1, 6)) put($urandom_range(3), $urandom_range(255));
         end
      end
   endtask

   initial begin
      int base_count;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: reset contents, pointer wrap, table entry fold, zero coarse count
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'd9,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'hFF, 1'b1, 8'd123, 1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'd8,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'd127, 1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'd4,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_SET_PTR, 8'hFD, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_WRITE,   8'd200, 1'b1, 8'd0,  1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_WRITE,   8'hFF, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_WRITE,   8'h00, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_SET_PTR, 8'hFE, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'hFF,  1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'h00,  1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_SET_PTR, 8'h01, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_WRITE,   8'h00, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_FINE);
      add_row(i2crb_pkg::OP_WRITE,   8'h00, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_FINE);
      add_row(i2crb_pkg::OP_TICK,    8'hAA, 1'b1, 8'd0,   1'b1, i2crb_pkg::PH_FINE);
      add_row(i2crb_pkg::OP_TICK,    8'h55, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_FINE);
      add_row(i2crb_pkg::OP_SET_PTR, 8'h09, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_FINE);
      add_row(i2crb_pkg::OP_WRITE,   8'h02, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_WRITE,   8'h01, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_WRITE,   8'hFF, 1'b1, 8'd0,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_READ,    8'h00, 1'b1, 8'd4,   1'b0, i2crb_pkg::PH_COARSE);
      add_row(i2crb_pkg::OP_TICK,    8'hFF, 1'b0, 8'd0,   1'b0, i2crb_pkg::PH_STOP);
      foreach (directed_rows[i]) offer_item(directed_rows[i]);
      wait_drained();

      // Random part in three pacing phases; long receiver hold-off at the start
      base_count = items_sent;
      send_idle_pct  = 32;
      recv_stall_pct = 51;
      hold_request   = 1'b1;
      run_random(base_count + RANDOM_ITEMS / 3);
      wait_drained();

      send_idle_pct  = 51;
      recv_stall_pct = 32;
      run_random(base_count + 2 * RANDOM_ITEMS / 3);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(base_count + RANDOM_ITEMS);
      wait_drained();

      repeat (SETTLE) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0d expected results never arrived", pending_results.size());
      end

      $display("Ran %0d items: %0d pointer sets, %0d writes, %0d reads, %0d ticks",
               items_sent, op_seen[i2crb_pkg::OP_SET_PTR], op_seen[i2crb_pkg::OP_WRITE],
               op_seen[i2crb_pkg::OP_READ], op_seen[i2crb_pkg::OP_TICK]);
      $display("Timer reached the fine lap %0d times and toggled onset %0d times; %0d errors",
               fine_entries, onset_toggles, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/i2crb_pkg.sv
design/i2crb_pair_mem.sv
design/i2c_register_bank_coarse_fine_timer_top.sv
tb/tb.sv
